### sv/mnc_pkg.sv
package mnc_pkg;

	// Line buffer depth and field widths
	localparam int MAX_COLS  = 32;
	localparam int COL_W     = 5;
	localparam int COLS_W    = COL_W + 1;
	localparam int ROW_W     = 10;
	localparam int CFG_W     = 10;
	localparam int CNT_W     = 4;
	localparam int REG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

	// One column of the 3x3 window: rows above, middle, below
	typedef struct packed {
		logic up;
		logic mid;
		logic low;
	} mnc_col_t;

	// Contents of one line buffer cell: two earlier rows at one column
	typedef struct packed {
		logic a;
		logic b;
	} mnc_cell_t;

	// Shift and clear controls for the chain and the window
	typedef struct packed {
		logic shift;
		logic clear;
	} mnc_shift_t;

endpackage

### sv/mnc_cell.sv
module mnc_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  mnc_pkg::mnc_shift_t ctrl,
	input  logic               insert,
	input  mnc_pkg::mnc_cell_t  ins_d,
	input  mnc_pkg::mnc_cell_t  nxt_d,
	output mnc_pkg::mnc_cell_t  q
);
	import mnc_pkg::*;

	mnc_cell_t data_q;

	// Take the neighbor's bits on a shift, or the new column at the insert point; clear zeroes the cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (ctrl.clear) begin
			data_q <= '0;
		end else if (ctrl.shift) begin
			data_q <= insert ? ins_d : nxt_d;
		end
	end

	assign q = data_q;

endmodule

### sv/mnc_window.sv
module mnc_window (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mnc_pkg::mnc_shift_t             ctrl,
	input  mnc_pkg::mnc_col_t               cur,
	output logic                           res_mine,
	output logic [mnc_pkg::CNT_W-1:0]      res_count
);
	import mnc_pkg::*;

	mnc_col_t p1_q;
	mnc_col_t p2_q;
	logic [CNT_W-1:0] sum;

	// Hold the two previous columns; the center column is p1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q <= '0;
			p2_q <= '0;
		end else if (ctrl.clear) begin
			p1_q <= '0;
			p2_q <= '0;
		end else if (ctrl.shift) begin
			p2_q <= p1_q;
			p1_q <= cur;
		end
	end

	// Count the eight neighbors of the center cell
	always_comb begin
		sum = CNT_W'(p2_q.up) + CNT_W'(p2_q.mid) + CNT_W'(p2_q.low)
			+ CNT_W'(p1_q.up) + CNT_W'(p1_q.low)
			+ CNT_W'(cur.up) + CNT_W'(cur.mid) + CNT_W'(cur.low);
	end

	assign res_mine  = p1_q.mid;
	assign res_count = p1_q.mid ? '0 : sum;

endmodule

### sv/mine_neighbor_counter.sv
// Results: an inner cell (r,c) has its result loaded into the output register at the edge that
// accepts cell (r+1,c+1); a row's last result is loaded from the tail state when the output is free.
// Flow: one cell per cycle inside a row while the output is free; the last cell of a row after
// the first is followed by a tail state for the extra row-end result. The frame's last cell is
// followed by a flush that shifts the line buffer chain once per column of the final row.
// Reset: arst_n clears counters, line buffer and window, and sets both frame registers to 1.
module mine_neighbor_counter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mnc_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [mnc_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cell_is_mine,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              out_is_mine,
	output logic [mnc_pkg::CNT_W-1:0]         mine_count,
	output logic                              row_end,
	output logic                              frame_end,
	output logic                              last_of_run
);
	import mnc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_TAIL  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t            state_q, state_d;
	logic [ROW_W-1:0]  frame_rows_q;
	logic [COLS_W-1:0] frame_cols_q;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [COLS_W-1:0] flush_q, flush_d;
	logic              frame_last_q, frame_last_d;

	logic [COLS_W-1:0] cols_eff;
	logic [COLS_W-1:0] cols_m1;
	logic [COL_W-1:0]  last_col;
	logic [ROW_W-1:0]  rows_eff;
	logic [ROW_W-1:0]  last_row;

	logic              out_free;
	logic              accept;
	logic              row_last;
	logic              first_row;
	logic              frame_last;

	mnc_shift_t        chain_ctrl;
	mnc_shift_t        win_ctrl;
	mnc_cell_t         ins_d;
	mnc_cell_t         cell_q [MAX_COLS];
	mnc_col_t          cur;
	logic              res_mine;
	logic [CNT_W-1:0]  res_count;

	logic              emit;
	logic              emit_row_end;
	logic              emit_frame_end;
	logic              emit_last;

	logic              out_valid_q;
	logic              out_is_mine_q;
	logic [CNT_W-1:0]  mine_count_q;
	logic              row_end_q;
	logic              frame_end_q;
	logic              last_of_run_q;

	// Clamp the frame size: columns to 1..MAX_COLS, rows to at least one; rows need no upper clamp
	always_comb begin
		if (frame_cols_q == '0) begin
			cols_eff = COLS_W'(1);
		end else if (frame_cols_q > COLS_W'(MAX_COLS)) begin
			cols_eff = COLS_W'(MAX_COLS);
		end else begin
			cols_eff = frame_cols_q;
		end
		cols_m1  = cols_eff - COLS_W'(1);
		last_col = cols_m1[COL_W-1:0];
		rows_eff = (frame_rows_q == '0) ? ROW_W'(1) : frame_rows_q;
		last_row = rows_eff - ROW_W'(1);
	end

	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == ST_IDLE) && out_free;
	assign accept     = in_valid && in_ready;
	assign row_last   = (col_q == last_col);
	assign first_row  = (row_q == '0);
	assign frame_last = row_last && (row_q == last_row);

	// Accept cells, sequence row tails and the end-of-frame flush
	always_comb begin
		state_d        = state_q;
		row_d          = row_q;
		col_d          = col_q;
		flush_d        = flush_q;
		frame_last_d   = frame_last_q;
		chain_ctrl     = '0;
		win_ctrl       = '0;
		ins_d          = '0;
		cur            = '0;
		emit           = 1'b0;
		emit_row_end   = 1'b0;
		emit_frame_end = 1'b0;
		emit_last      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cur   = '{up: cell_q[0].a, mid: cell_q[0].b, low: cell_is_mine};
				ins_d = '{a: cell_q[0].b, b: cell_is_mine};
				if (accept) begin
					chain_ctrl.shift = 1'b1;
					emit      = !first_row && (col_q != '0);
					emit_last = !(row_last && (!first_row || frame_last));
					if (row_last) begin
						col_d        = '0;
						row_d        = frame_last ? '0 : row_q + ROW_W'(1);
						frame_last_d = frame_last;
						if (!first_row) begin
							win_ctrl.shift = 1'b1;
							state_d        = ST_TAIL;
						end else begin
							win_ctrl.clear = 1'b1;
							if (frame_last) begin
								flush_d = '0;
								state_d = ST_FLUSH;
							end
						end
					end else begin
						win_ctrl.shift = 1'b1;
						col_d          = col_q + COL_W'(1);
					end
				end
			end
			ST_TAIL: begin
				if (out_free) begin
					emit           = 1'b1;
					emit_row_end   = 1'b1;
					emit_last      = !frame_last_q;
					win_ctrl.clear = 1'b1;
					if (frame_last_q) begin
						flush_d = '0;
						state_d = ST_FLUSH;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				if (flush_q < cols_eff) begin
					cur = '{up: cell_q[0].a, mid: cell_q[0].b, low: 1'b0};
				end
				if (out_free) begin
					emit           = (flush_q != '0);
					emit_row_end   = (flush_q == cols_eff);
					emit_frame_end = emit_row_end;
					emit_last      = emit_row_end;
					if (flush_q == cols_eff) begin
						chain_ctrl.clear = 1'b1;
						win_ctrl.clear   = 1'b1;
						state_d          = ST_IDLE;
					end else begin
						chain_ctrl.shift = 1'b1;
						win_ctrl.shift   = 1'b1;
						flush_d          = flush_q + COLS_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// Restart the frame on a write to either frame register
		if (cfg_we && ((cfg_index == REG_FRAME_ROWS) || (cfg_index == REG_FRAME_COLS))) begin
			chain_ctrl.clear = 1'b1;
			win_ctrl.clear   = 1'b1;
			state_d          = ST_IDLE;
			row_d            = '0;
			col_d            = '0;
		end
	end

	// Hold configuration, position and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			frame_rows_q <= ROW_W'(1);
			frame_cols_q <= COLS_W'(1);
			row_q        <= '0;
			col_q        <= '0;
			flush_q      <= '0;
			frame_last_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			row_q        <= row_d;
			col_q        <= col_d;
			flush_q      <= flush_d;
			frame_last_q <= frame_last_d;
			if (cfg_we && (cfg_index == REG_FRAME_ROWS)) begin
				frame_rows_q <= cfg_data[ROW_W-1:0];
			end
			if (cfg_we && (cfg_index == REG_FRAME_COLS)) begin
				frame_cols_q <= cfg_data[COLS_W-1:0];
			end
		end
	end

	// Line buffer: a chain of cells that shifts toward cell 0, fed at the last column
	for (genvar i = 0; i < MAX_COLS; i++) begin : g_chain
		mnc_cell_t nxt;
		if (i == MAX_COLS - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_q[i+1];
		end
		mnc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (chain_ctrl),
			.insert (last_col == COL_W'(i)),
			.ins_d  (ins_d),
			.nxt_d  (nxt),
			.q      (cell_q[i])
		);
	end

	mnc_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (win_ctrl),
		.cur       (cur),
		.res_mine  (res_mine),
		.res_count (res_count)
	);

	// Output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_is_mine_q <= res_mine;
			mine_count_q  <= res_count;
			row_end_q     <= emit_row_end;
			frame_end_q   <= emit_frame_end;
			last_of_run_q <= emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_is_mine = out_is_mine_q;
	assign mine_count  = mine_count_q;
	assign row_end     = row_end_q;
	assign frame_end   = frame_end_q;
	assign last_of_run = last_of_run_q;

`ifndef NO_ASSERTIONS
	a_flush_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (flush_q <= cols_eff))
		else $error("flush counter ran past the frame width");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (col_q <= last_col))
		else $error("column counter ran past the frame width");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> (row_end && last_of_run))
		else $error("frame end without row end and last of run");

	a_mine_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_is_mine && (mine_count == '0))
			|| (!out_is_mine && (mine_count <= CNT_W'(8)))))
		else $error("neighbor count out of range");
`endif

endmodule
